// File: hw/rtl/hopf_pkg.sv
// Shared types, constants and helpers for the coupled Hopf oscillator step block.
// Holds the fixed-point format, the microcode table and the control structs.
// No dependencies.
package hopf_pkg;

  // Fixed-point format and history length
  localparam int FRAC_BITS     = 16;
  localparam int HISTORY_DEPTH = 2;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = DATA_W + 3;

  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -64'sh8000_0000;

  // Fixed-point constants derived from the format
  localparam longint Q_ONE    = longint'(1) << FRAC_BITS;
  localparam longint TWO_PI_Q = ((longint'(628) << FRAC_BITS) + 50) / 100;
  localparam longint TENTH_Q  = ((longint'(1) << FRAC_BITS) + 5) / 10;

  localparam logic signed [DATA_W-1:0] RST_U     = DATA_W'(-Q_ONE);
  localparam logic signed [DATA_W-1:0] RST_V     = DATA_W'(-TENTH_Q);
  localparam logic signed [DATA_W-1:0] TWO_PI_OP = DATA_W'(TWO_PI_Q);
  localparam logic signed [DATA_W-1:0] GAIN_TEN  = DATA_W'(10);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int STEP_W     = 17;
  localparam int FREQ_W     = 20;
  localparam int PHASE_W    = 18;
  localparam int AMP_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE = 3'd0,
    CFG_FREQUENCY = 3'd1,
    CFG_COS_PHASE = 3'd2,
    CFG_SIN_PHASE = 3'd3,
    CFG_AMPLITUDE = 3'd4
  } cfg_idx_t;

  localparam logic [STEP_W-1:0]         RST_STEP = STEP_W'(1311);
  localparam logic [FREQ_W-1:0]         RST_FREQ = FREQ_W'(16384);
  localparam logic signed [PHASE_W-1:0] RST_COS  = PHASE_W'(65536);
  localparam logic signed [PHASE_W-1:0] RST_SIN  = '0;
  localparam logic [AMP_W-1:0]          RST_AMP  = AMP_W'(1);

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8 * DATA_W;

  typedef struct packed {
    logic [STEP_W-1:0]         h;
    logic [FREQ_W-1:0]         freq;
    logic signed [PHASE_W-1:0] c;
    logic signed [PHASE_W-1:0] s;
    logic [AMP_W-1:0]          amp;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] u1;
    logic signed [DATA_W-1:0] v1;
    logic signed [DATA_W-1:0] u2;
    logic signed [DATA_W-1:0] v2;
  } osc_t;

  // Multiplier operand sources
  typedef enum logic [3:0] {
    SRC_U1, SRC_V1, SRC_U2, SRC_V2, SRC_W, SRC_G1, SRC_G2, SRC_D,
    SRC_C, SRC_S, SRC_H, SRC_FREQ, SRC_TWOPI, SRC_TEN
  } src_t;

  // Extra addend for the accumulator
  typedef enum logic [2:0] {
    EXT_NONE, EXT_A2, EXT_U1, EXT_V1, EXT_U2, EXT_V2, EXT_K1, EXT_K2
  } ext_t;

  // Scratch register written at the end of a sum
  typedef enum logic [3:0] {
    DST_W, DST_G1, DST_G2, DST_K1, DST_K2, DST_D,
    DST_NU1, DST_NV1, DST_NU2, DST_NV2
  } dst_t;

  typedef struct packed {
    src_t src_a;
    src_t src_b;
    logic int_mode;   // product used unshifted
    logic clr;        // start a new sum
    logic sub;        // subtract the product
    ext_t ext;
    logic wr;         // saturate the sum into dst
    dst_t dst;
  } uop_t;

  typedef struct packed {
    logic ready;
    logic mul_en;
    logic acc_en;
    logic fin;
    logic step;
    uop_t uop;
  } ctrl_t;

  localparam int NUM_UOPS  = 23;
  localparam int UOP_IDX_W = $clog2(NUM_UOPS);

  // Microcode: one product per entry, accumulated into a sum that is saturated when written
  function automatic uop_t uop_at(input logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    u = '{SRC_U1, SRC_U1, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b0, DST_W};
    case (idx)
      // rotation rate
      5'd0:  u = '{SRC_TWOPI, SRC_FREQ, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b1, DST_W};
      // gain of oscillator one
      5'd1:  u = '{SRC_U1, SRC_U1, 1'b0, 1'b1, 1'b1, EXT_A2,   1'b0, DST_G1};
      5'd2:  u = '{SRC_V1, SRC_V1, 1'b0, 1'b0, 1'b1, EXT_NONE, 1'b1, DST_G1};
      5'd3:  u = '{SRC_G1, SRC_TEN, 1'b1, 1'b1, 1'b0, EXT_NONE, 1'b1, DST_G1};
      // gain of oscillator two
      5'd4:  u = '{SRC_U2, SRC_U2, 1'b0, 1'b1, 1'b1, EXT_A2,   1'b0, DST_G2};
      5'd5:  u = '{SRC_V2, SRC_V2, 1'b0, 1'b0, 1'b1, EXT_NONE, 1'b1, DST_G2};
      5'd6:  u = '{SRC_G2, SRC_TEN, 1'b1, 1'b1, 1'b0, EXT_NONE, 1'b1, DST_G2};
      // coupling terms
      5'd7:  u = '{SRC_V2, SRC_C, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b0, DST_K1};
      5'd8:  u = '{SRC_U2, SRC_S, 1'b0, 1'b0, 1'b1, EXT_NONE, 1'b1, DST_K1};
      5'd9:  u = '{SRC_U1, SRC_S, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b0, DST_K2};
      5'd10: u = '{SRC_V1, SRC_C, 1'b0, 1'b0, 1'b0, EXT_NONE, 1'b1, DST_K2};
      // oscillator one u
      5'd11: u = '{SRC_G1, SRC_U1, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b0, DST_D};
      5'd12: u = '{SRC_W,  SRC_V1, 1'b0, 1'b0, 1'b1, EXT_NONE, 1'b1, DST_D};
      5'd13: u = '{SRC_D,  SRC_H,  1'b0, 1'b1, 1'b0, EXT_U1,   1'b1, DST_NU1};
      // oscillator one v
      5'd14: u = '{SRC_G1, SRC_V1, 1'b0, 1'b1, 1'b0, EXT_K1,   1'b0, DST_D};
      5'd15: u = '{SRC_W,  SRC_U1, 1'b0, 1'b0, 1'b0, EXT_NONE, 1'b1, DST_D};
      5'd16: u = '{SRC_D,  SRC_H,  1'b0, 1'b1, 1'b0, EXT_V1,   1'b1, DST_NV1};
      // oscillator two u
      5'd17: u = '{SRC_G2, SRC_U2, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b0, DST_D};
      5'd18: u = '{SRC_W,  SRC_V2, 1'b0, 1'b0, 1'b1, EXT_NONE, 1'b1, DST_D};
      5'd19: u = '{SRC_D,  SRC_H,  1'b0, 1'b1, 1'b0, EXT_U2,   1'b1, DST_NU2};
      // oscillator two v
      5'd20: u = '{SRC_G2, SRC_V2, 1'b0, 1'b1, 1'b0, EXT_K2,   1'b0, DST_D};
      5'd21: u = '{SRC_W,  SRC_U2, 1'b0, 1'b0, 1'b0, EXT_NONE, 1'b1, DST_D};
      5'd22: u = '{SRC_D,  SRC_H,  1'b0, 1'b1, 1'b0, EXT_V2,   1'b1, DST_NV2};
      default: u = '{SRC_U1, SRC_U1, 1'b0, 1'b1, 1'b0, EXT_NONE, 1'b0, DST_W};
    endcase
    return u;
  endfunction

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > I32_MAX) begin
      r = DATA_W'(I32_MAX);
    end else if (x < I32_MIN) begin
      r = DATA_W'(I32_MIN);
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/coupled_hopf_oscillator_step_top.sv
// Top level of the coupled Hopf oscillator step: configuration registers,
// oscillator state and history, output register. Depends on hopf_pkg,
// hopf_seq and hopf_alu.
//
//  channel | direction | payload
//  in_     | slave     | tdata[0] advance
//  out_    | master    | tdata: first_u, first_v, second_u, second_v, first_u_older1,
//          |           |        first_u_older2, second_u_older1, second_u_older2
//  cfg_    | slave     | cfg_index register number, cfg_data value
//
// A beat with advance set runs 23 products through one shared multiplier, each
// in a multiply then an accumulate state, then finishes; a beat with advance
// clear goes straight to finish. in_tready is high only while the sequencer is
// idle. A finished result waits in the output register while the next input beat
// is accepted; the next result is held until out_tready frees it.
// Reset is synchronous, active low, and restores state, history and registers.
module coupled_hopf_oscillator_step_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hopf_pkg::IN_DATA_W-1:0]      in_tdata,   // [0] advance, rest zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] first_u, [63:32] first_v, [95:64] second_u, [127:96] second_v,
  // [159:128] first_u_older1, [191:160] first_u_older2,
  // [223:192] second_u_older1, [255:224] second_u_older2
  output logic [hopf_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hopf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hopf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hopf_pkg::*;

  localparam int OLD2_IDX = (HISTORY_DEPTH > 1) ? 1 : 0;

  cfg_t  cfg_r;
  osc_t  osc_r, osc_nxt, osc_new;
  ctrl_t ctrl;

  logic signed [DATA_W-1:0] hist1_r [HISTORY_DEPTH];
  logic signed [DATA_W-1:0] hist2_r [HISTORY_DEPTH];
  logic signed [DATA_W-1:0] hist1_nxt [HISTORY_DEPTH];
  logic signed [DATA_W-1:0] hist2_nxt [HISTORY_DEPTH];
  logic signed [DATA_W-1:0] old1_2, old2_2;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  in_beat, out_free;

  assign in_tready = ctrl.ready;
  assign in_beat   = in_tvalid && ctrl.ready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  hopf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_beat),
    .advance  (in_tdata[0]),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  hopf_alu u_alu (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (cfg_r),
    .osc     (osc_r),
    .osc_new (osc_new)
  );

  // Configuration writes; high bits beyond each register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{RST_STEP, RST_FREQ, RST_COS, RST_SIN, RST_AMP};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_SIZE: cfg_r.h    <= cfg_data[STEP_W-1:0];
        CFG_FREQUENCY: cfg_r.freq <= cfg_data[FREQ_W-1:0];
        CFG_COS_PHASE: cfg_r.c    <= cfg_data[PHASE_W-1:0];
        CFG_SIN_PHASE: cfg_r.s    <= cfg_data[PHASE_W-1:0];
        CFG_AMPLITUDE: cfg_r.amp  <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Commit a step: shift history, take the new state
  always_comb begin
    osc_nxt   = osc_r;
    hist1_nxt = hist1_r;
    hist2_nxt = hist2_r;
    if (ctrl.step) begin
      osc_nxt = osc_new;
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
        hist1_nxt[k] = hist1_r[k-1];
        hist2_nxt[k] = hist2_r[k-1];
      end
      hist1_nxt[0] = osc_r.u1;
      hist2_nxt[0] = osc_r.u2;
    end
  end

  // Pack the result beat from the committed state
  always_comb begin
    old1_2 = (HISTORY_DEPTH > 1) ? hist1_nxt[OLD2_IDX] : '0;
    old2_2 = (HISTORY_DEPTH > 1) ? hist2_nxt[OLD2_IDX] : '0;
    out_data_nxt = {old2_2, hist2_nxt[0], old1_2, hist1_nxt[0],
                    osc_nxt.v2, osc_nxt.u2, osc_nxt.v1, osc_nxt.u1};
  end

  // Oscillator state and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r <= '{RST_U, RST_V, RST_U, RST_V};
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist1_r[k] <= '0;
        hist2_r[k] <= '0;
      end
    end else if (ctrl.fin) begin
      osc_r   <= osc_nxt;
      hist1_r <= hist1_nxt;
      hist2_r <= hist2_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/hopf_seq.sv
// Sequencer for the oscillator step: walks the microcode table, one product
// per multiply state and accumulate state, and hands the finished step to the
// output side. Depends on hopf_pkg.
module hopf_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,      // input beat accepted
  input  logic            advance,    // accepted beat asks for a step
  input  logic            out_free,   // output register can take a beat
  output hopf_pkg::ctrl_t ctrl
);
  import hopf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  localparam logic [UOP_IDX_W-1:0] LAST_UOP = UOP_IDX_W'(NUM_UOPS - 1);

  state_t               state_r, state_nxt;
  logic [UOP_IDX_W-1:0] idx_r, idx_nxt;
  logic                 adv_r, adv_nxt;

  // Next state and microcode index
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    adv_nxt   = adv_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          adv_nxt   = advance;
          idx_nxt   = '0;
          state_nxt = advance ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (idx_r == LAST_UOP) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      adv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      adv_r   <= adv_nxt;
    end
  end

  // Control to the datapath and the output side
  always_comb begin
    ctrl.ready  = (state_r == ST_IDLE);
    ctrl.mul_en = (state_r == ST_MUL);
    ctrl.acc_en = (state_r == ST_ACC);
    ctrl.fin    = (state_r == ST_FIN) && out_free;
    ctrl.step   = (state_r == ST_FIN) && out_free && adv_r;
    ctrl.uop    = uop_at(idx_r);
  end

endmodule

// File: hw/rtl/hopf_alu.sv
// Shared multiply-accumulate unit with saturation and its scratch registers.
// One signed 32x32 product per use, registered, then shifted (unless in integer mode), clamped and summed.
// Depends on hopf_pkg.
module hopf_alu (
  input  logic            clk,
  input  hopf_pkg::ctrl_t ctrl,
  input  hopf_pkg::cfg_t  cfg,
  input  hopf_pkg::osc_t  osc,
  output hopf_pkg::osc_t  osc_new
);
  import hopf_pkg::*;

  localparam int A2_W = DATA_W + 2 * AMP_W;

  logic signed [DATA_W-1:0] w_r, g1_r, g2_r, k1_r, k2_r, d_r;
  logic signed [DATA_W-1:0] nu1_r, nv1_r, nu2_r, nv2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [DATA_W-1:0] op_a, op_b, ext_val, m, sum_sat, a2;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  base, term, sum;
  logic [2*AMP_W-1:0]       amp_sq;
  logic [A2_W-1:0]          a2_wide;

  // Select one multiplier operand
  function automatic logic signed [DATA_W-1:0] pick(input src_t sel,
                                                    input logic signed [DATA_W-1:0] w,
                                                    input logic signed [DATA_W-1:0] g1,
                                                    input logic signed [DATA_W-1:0] g2,
                                                    input logic signed [DATA_W-1:0] d,
                                                    input osc_t o,
                                                    input cfg_t c);
    logic signed [DATA_W-1:0] r;
    case (sel)
      SRC_U1:    r = o.u1;
      SRC_V1:    r = o.v1;
      SRC_U2:    r = o.u2;
      SRC_V2:    r = o.v2;
      SRC_W:     r = w;
      SRC_G1:    r = g1;
      SRC_G2:    r = g2;
      SRC_D:     r = d;
      SRC_C:     r = DATA_W'(c.c);
      SRC_S:     r = DATA_W'(c.s);
      SRC_H:     r = DATA_W'({1'b0, c.h});
      SRC_FREQ:  r = DATA_W'({1'b0, c.freq});
      SRC_TWOPI: r = TWO_PI_OP;
      SRC_TEN:   r = GAIN_TEN;
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Squared amplitude in fixed point, clamped
  always_comb begin
    amp_sq  = (2*AMP_W)'(cfg.amp) * (2*AMP_W)'(cfg.amp);
    a2_wide = A2_W'(amp_sq) << FRAC_BITS;
    if (a2_wide > A2_W'(I32_MAX)) begin
      a2 = DATA_W'(I32_MAX);
    end else begin
      a2 = a2_wide[DATA_W-1:0];
    end
  end

  assign op_a = pick(ctrl.uop.src_a, w_r, g1_r, g2_r, d_r, osc, cfg);
  assign op_b = pick(ctrl.uop.src_b, w_r, g1_r, g2_r, d_r, osc, cfg);

  // Extra addend
  always_comb begin
    case (ctrl.uop.ext)
      EXT_A2:  ext_val = a2;
      EXT_U1:  ext_val = osc.u1;
      EXT_V1:  ext_val = osc.v1;
      EXT_U2:  ext_val = osc.u2;
      EXT_V2:  ext_val = osc.v2;
      EXT_K1:  ext_val = k1_r;
      EXT_K2:  ext_val = k2_r;
      default: ext_val = '0;
    endcase
  end

  // Scale, clamp and accumulate the registered product
  always_comb begin
    shifted = ctrl.uop.int_mode ? prod_r : (prod_r >>> FRAC_BITS);
    m       = sat32(shifted);
    base    = ctrl.uop.clr ? '0 : acc_r;
    term    = ctrl.uop.sub ? -ACC_W'(m) : ACC_W'(m);
    sum     = base + term + ACC_W'(ext_val);
    sum_sat = sat32(PROD_W'(sum));
  end

  // Product register
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  // Accumulator and scratch writeback
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_r <= sum;
      if (ctrl.uop.wr) begin
        case (ctrl.uop.dst)
          DST_W:   w_r   <= sum_sat;
          DST_G1:  g1_r  <= sum_sat;
          DST_G2:  g2_r  <= sum_sat;
          DST_K1:  k1_r  <= sum_sat;
          DST_K2:  k2_r  <= sum_sat;
          DST_D:   d_r   <= sum_sat;
          DST_NU1: nu1_r <= sum_sat;
          DST_NV1: nv1_r <= sum_sat;
          DST_NU2: nu2_r <= sum_sat;
          DST_NV2: nv2_r <= sum_sat;
          default: d_r   <= sum_sat;
        endcase
      end
    end
  end

  assign osc_new = '{nu1_r, nv1_r, nu2_r, nv2_r};

endmodule
